// ===== hdl/lwma_pkg.sv =====
// Shared constants for the LWMA difficulty retarget block.
// Field widths, register map, reset values and default parameters.
// No dependencies.
package lwma_pkg;

  // Fixed field widths.
  localparam int TS_W    = 40;  // block_timestamp, genesis_timestamp
  localparam int TGT_W   = 64;  // Q0.64 targets
  localparam int IDEAL_W = 16;  // ideal_block_time

  // Default parameters.
  localparam int WINDOW_DEF    = 60;
  localparam int TIME_BITS_DEF = 40;

  // Configuration port: 64-bit registers at byte address 8*i.
  localparam int APB_DW    = 64;
  localparam int REG_IDX_W = 2;
  localparam int APB_AW    = REG_IDX_W + 3;

  localparam logic [REG_IDX_W-1:0] REG_IDEAL   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INIT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GENESIS = 2'd2;

  // Register reset values.
  localparam logic [IDEAL_W-1:0] IDEAL_RST   = 16'd600;
  localparam logic [TGT_W-1:0]   INIT_RST    = 64'h0000_0001_0000_0000;
  localparam logic [TS_W-1:0]    GENESIS_RST = 40'd63399218400;

endpackage

// ===== hdl/lwma_difficulty_retarget.sv =====
// Channel  Dir  Width  Contents
// s_axis   in   40     block_timestamp
// m_axis   out  64+1   next_target in tdata, warming_up in tuser
// apb      in   64     ideal_block_time, initial_target, genesis_timestamp
//
// One block at a time. A warm-up result goes through the ST_OUT state into the
// output register with no walk. A retarget result first takes the window walk,
// which reads one ring slot per cycle, then the multiplier, which steps through
// the bits of the weighted time W, and the divider, which steps through the
// product bits P. The input is ready again once the result moves into the
// output register; a second result waits while that register is still full.
// No clearing pass after reset. Depends on lwma_pkg, lwma_walk, lwma_mul, lwma_div.
module lwma_difficulty_retarget
  import lwma_pkg::*;
#(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [TS_W-1:0]   s_axis_tdata_i,   // [39:0] block_timestamp
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TGT_W-1:0]  m_axis_tdata_o,   // [63:0] next_target
  output logic              m_axis_tuser_o,   // [0] warming_up
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int DEPTH = WINDOW + 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(WINDOW + 2);
  localparam int WSUM  = WINDOW * (WINDOW + 1) / 2;
  localparam int W_W   = TIME_BITS + $clog2(WSUM + 1);
  localparam int T_W   = TGT_W + $clog2(WINDOW + 1);
  localparam int P_W   = T_W + W_W;
  localparam int DK    = WINDOW * WSUM;
  localparam int D_W   = IDEAL_W + $clog2(DK + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]         state_q;
  logic [IDEAL_W-1:0] ideal_q;
  logic [TGT_W-1:0]   init_q;
  logic [TS_W-1:0]    gen_q;
  logic [TGT_W-1:0]   cur_tgt_q;
  logic [CNT_W-1:0]   cnt_q, cnt_nx;
  logic [PTR_W-1:0]   head_q, head_nx;
  logic               warm_q, warm_nx;
  logic               gen_wr_q, walk_start_q;
  logic               m_valid_q, m_user_q;
  logic [TGT_W-1:0]   m_data_q;

  logic                 accept, out_free, cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  logic                 ts_we, tg_we;
  logic [PTR_W-1:0]     waddr;
  logic [TIME_BITS-1:0] wts;
  logic [TGT_W-1:0]     wtg;

  logic             walk_done, mul_done, div_done;
  logic [T_W-1:0]   tsum;
  logic [W_W-1:0]   wsum;
  logic [P_W-1:0]   prod;
  logic [D_W-1:0]   div_d;
  logic [TGT_W-1:0] div_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[APB_AW-1:3];
  assign pready   = 1'b1;

  assign head_nx = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign cnt_nx  = (cnt_q <= CNT_W'(WINDOW)) ? cnt_q + 1'b1 : cnt_q;
  assign warm_nx = (cnt_nx <= CNT_W'(WINDOW));

  assign div_d = D_W'(ideal_q) * D_W'(DK);

  always_comb begin
    unique case (cfg_idx)
      REG_IDEAL:   prdata = {{(APB_DW - IDEAL_W){1'b0}}, ideal_q};
      REG_INIT:    prdata = init_q;
      REG_GENESIS: prdata = {{(APB_DW - TS_W){1'b0}}, gen_q};
      default:     prdata = '0;
    endcase
  end

  // The genesis slot is written in the cycle after the first block, with
  // the genesis value in force when that block arrived.
  always_comb begin
    ts_we = 1'b0;
    tg_we = 1'b0;
    waddr = head_nx;
    wts   = TIME_BITS'(s_axis_tdata_i);
    wtg   = cur_tgt_q;
    if (accept) begin
      ts_we = 1'b1;
      tg_we = 1'b1;
    end else if (gen_wr_q) begin
      ts_we = 1'b1;
      waddr = '0;
      wts   = TIME_BITS'(gen_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ideal_q      <= IDEAL_RST;
      init_q       <= INIT_RST;
      gen_q        <= TS_W'(TIME_BITS'(GENESIS_RST));
      cur_tgt_q    <= INIT_RST;
      cnt_q        <= '0;
      head_q       <= '0;
      gen_wr_q     <= 1'b0;
      walk_start_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      walk_start_q <= 1'b0;
      gen_wr_q     <= accept && (cnt_q == '0);
      if ((state_q == ST_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_IDEAL: ideal_q <= pwdata[IDEAL_W-1:0];
          REG_INIT: begin
            init_q <= pwdata;
            if (cnt_q <= CNT_W'(WINDOW)) begin
              cur_tgt_q <= pwdata;
            end
          end
          REG_GENESIS: gen_q <= TS_W'(TIME_BITS'(pwdata[TS_W-1:0]));
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            head_q <= head_nx;
            cnt_q  <= cnt_nx;
            if (warm_nx) begin
              cur_tgt_q <= init_q;
              state_q   <= ST_OUT;
            end else begin
              walk_start_q <= 1'b1;
              state_q      <= ST_BUSY;
            end
          end
        end
        ST_BUSY: begin
          if (div_done) begin
            cur_tgt_q <= div_q;
            state_q   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      warm_q <= warm_nx;
    end
    if ((state_q == ST_OUT) && out_free) begin
      m_data_q <= cur_tgt_q;
      m_user_q <= warm_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  lwma_walk #(
    .WINDOW    (WINDOW),
    .TIME_BITS (TIME_BITS)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ts_we_i    (ts_we),
    .tg_we_i    (tg_we),
    .waddr_i    (waddr),
    .ts_wdata_i (wts),
    .tg_wdata_i (wtg),
    .start_i    (walk_start_q),
    .head_i     (head_q),
    .done_o     (walk_done),
    .tsum_o     (tsum),
    .wsum_o     (wsum)
  );

  lwma_mul #(
    .A_W (T_W),
    .B_W (W_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_done),
    .a_i     (tsum),
    .b_i     (wsum),
    .done_o  (mul_done),
    .p_o     (prod)
  );

  lwma_div #(
    .N_W (P_W),
    .D_W (D_W),
    .Q_W (TGT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_done),
    .n_i     (prod),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q)
  );

endmodule

// ===== hdl/lwma_walk.sv =====
// History rings and window walk: stores timestamps and targets, then
// walks the window to form the target sum and the linearly weighted time.
// Depends on lwma_pkg.
module lwma_walk
  import lwma_pkg::*;
#(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int DEPTH  = WINDOW + 2,
  localparam int PTR_W  = $clog2(DEPTH),
  localparam int ITER_W = $clog2(WINDOW + 1),
  localparam int WSUM   = WINDOW * (WINDOW + 1) / 2,
  localparam int R_W    = TIME_BITS + $clog2(WINDOW + 1),
  localparam int W_W    = TIME_BITS + $clog2(WSUM + 1),
  localparam int T_W    = TGT_W + $clog2(WINDOW + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ts_we_i,
  input  logic                 tg_we_i,
  input  logic [PTR_W-1:0]     waddr_i,
  input  logic [TIME_BITS-1:0] ts_wdata_i,
  input  logic [TGT_W-1:0]     tg_wdata_i,
  input  logic                 start_i,
  input  logic [PTR_W-1:0]     head_i,
  output logic                 done_o,
  output logic [T_W-1:0]       tsum_o,
  output logic [W_W-1:0]       wsum_o
);

  logic [TIME_BITS-1:0] ts_mem [DEPTH];
  logic [TGT_W-1:0]     tg_mem [DEPTH];
  logic [TIME_BITS-1:0] ts_rd_q;
  logic [TGT_W-1:0]     tg_rd_q;

  logic              busy_q;
  logic [ITER_W-1:0] iss_q;
  logic [PTR_W-1:0]  rptr_q;
  logic              rd_v_q, rd_first_q, rd_last_q, fin_q, done_q;

  logic [TIME_BITS-1:0] prev_q;
  logic [TIME_BITS-1:0] iv;
  logic [R_W-1:0]       r_q;
  logic [W_W-1:0]       w_q;
  logic [T_W-1:0]       t_q;

  always_ff @(posedge clk_i) begin
    if (ts_we_i) begin
      ts_mem[waddr_i] <= ts_wdata_i;
    end
    if (tg_we_i) begin
      tg_mem[waddr_i] <= tg_wdata_i;
    end
    ts_rd_q <= ts_mem[rptr_q];
    tg_rd_q <= tg_mem[rptr_q];
  end

  // Reads go from the block before the newest one back to the oldest
  // timestamp of the window, one slot per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      iss_q      <= '0;
      rptr_q     <= '0;
      rd_v_q     <= 1'b0;
      rd_first_q <= 1'b0;
      rd_last_q  <= 1'b0;
      fin_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      rd_v_q     <= busy_q;
      rd_first_q <= (iss_q == '0);
      rd_last_q  <= (iss_q == ITER_W'(WINDOW));
      fin_q      <= rd_v_q && rd_last_q;
      done_q     <= fin_q;
      if (start_i) begin
        busy_q <= 1'b1;
        iss_q  <= '0;
        rptr_q <= (head_i == '0) ? PTR_W'(DEPTH - 1) : head_i - 1'b1;
      end else if (busy_q) begin
        iss_q  <= iss_q + 1'b1;
        rptr_q <= (rptr_q == '0) ? PTR_W'(DEPTH - 1) : rptr_q - 1'b1;
        if (iss_q == ITER_W'(WINDOW)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // A non-increasing pair of timestamps counts as a zero interval.
  assign iv = (prev_q > ts_rd_q) ? prev_q - ts_rd_q : '0;

  // Walking from newest to oldest, r_q is the running interval sum and
  // adding it once per step weights each interval by its position.
  // w_q trails r_q by one step; the finishing cycle adds the last sum.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      w_q <= '0;
      t_q <= '0;
    end else begin
      if (rd_v_q) begin
        prev_q <= ts_rd_q;
        if (!rd_first_q) begin
          r_q <= r_q + R_W'(iv);
          w_q <= w_q + W_W'(r_q);
        end
        if (!rd_last_q) begin
          t_q <= t_q + T_W'(tg_rd_q);
        end
      end
      if (fin_q) begin
        w_q <= w_q + W_W'(r_q);
      end
    end
  end

  assign done_o = done_q;
  assign tsum_o = t_q;
  assign wsum_o = w_q;

endmodule

// ===== hdl/lwma_mul.sv =====
// Shift-and-add multiplier: one multiplier bit per cycle.
// Depends on lwma_pkg.
module lwma_mul
  import lwma_pkg::*;
#(
  parameter int A_W = TGT_W,
  parameter int B_W = TS_W,
  localparam int P_W = A_W + B_W,
  localparam int C_W = $clog2(B_W + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  output logic           done_o,
  output logic [P_W-1:0] p_o
);

  logic           busy_q, done_q;
  logic [C_W-1:0] cnt_q;
  logic [A_W-1:0] a_q;
  logic [P_W-1:0] acc_q;
  logic [A_W:0]   sum;

  assign sum = {1'b0, acc_q[P_W-1:B_W]} + (acc_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == C_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= C_W'(B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == C_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // The multiplier sits in the low bits and shifts out as the product
  // grows in from the top.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {{A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ===== hdl/lwma_div.sv =====
// Restoring divider, one quotient bit per cycle, with saturation of the
// quotient to Q_W bits and on a zero divisor. Depends on lwma_pkg.
module lwma_div
  import lwma_pkg::*;
#(
  parameter int N_W = 2 * TGT_W,
  parameter int D_W = TS_W,
  parameter int Q_W = TGT_W,
  localparam int C_W = $clog2(N_W + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] n_i,
  input  logic [D_W-1:0] d_i,
  output logic           done_o,
  output logic [Q_W-1:0] q_o
);

  logic           busy_q, done_q;
  logic [C_W-1:0] cnt_q;
  logic [N_W-1:0] n_q;
  logic [D_W-1:0] d_q, r_q;
  logic [Q_W-1:0] q_q;
  logic           sat_q;
  logic [D_W:0]   r2, diff;
  logic           ge;

  assign r2   = {r_q, n_q[N_W-1]};
  assign diff = r2 - {1'b0, d_q};
  assign ge   = (r2 >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == C_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= C_W'(N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == C_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // A set quotient bit above the low Q_W bits means the result overflows.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n_i;
      d_q   <= d_i;
      r_q   <= '0;
      q_q   <= '0;
      sat_q <= (d_i == '0);
    end else if (busy_q) begin
      n_q <= {n_q[N_W-2:0], 1'b0};
      r_q <= ge ? diff[D_W-1:0] : r2[D_W-1:0];
      q_q <= {q_q[Q_W-2:0], ge};
      if (ge && (cnt_q > C_W'(Q_W))) begin
        sat_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = sat_q ? '1 : q_q;

endmodule

// ===== bench/lwma_difficulty_retarget_tb.sv =====
// Testbench for lwma_difficulty_retarget: block timestamps in, next targets out.
// An in-bench model predicts each result; randomized stalls on both streams.
// Depends on lwma_pkg and lwma_difficulty_retarget.
module lwma_difficulty_retarget_tb;
  import lwma_pkg::*;

  localparam int WIN           = WINDOW_DEF;
  localparam int DEPTH         = WIN + 2;
  localparam int STALL_LIMIT   = 10000;
  localparam int HOLD_CYCLES   = 2000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [TGT_W-1:0] next_target;
    logic             warming_up;
  } retarget_result_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [TS_W-1:0]   s_axis_tdata_i  = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [TGT_W-1:0]  m_axis_tdata_o;
  logic              m_axis_tuser_o;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [APB_AW-1:0] paddr           = '0;
  logic [APB_DW-1:0] pwdata          = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Model of the block's state and registers.
  logic [TS_W-1:0]    ts_hist [DEPTH];
  logic [TGT_W-1:0]   tgt_hist[DEPTH];
  logic [TGT_W-1:0]   cur_target  = INIT_RST;
  logic [TGT_W-1:0]   cfg_init    = INIT_RST;
  logic [IDEAL_W-1:0] cfg_ideal   = IDEAL_RST;
  int                 blocks_seen = 0;
  int                 head        = 0;

  retarget_result_t   pending_targets[$];
  logic [TS_W-1:0]    last_ts     = '0;
  int unsigned        sender_idle_pct   = 0;
  int unsigned        receiver_idle_pct = 0;
  logic               hold_output       = 1'b0;
  int                 mismatch_count    = 0;
  int                 stall_cycles      = 0;

  lwma_difficulty_retarget dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int slot_back(input int j);
    return (head + DEPTH - (j % DEPTH)) % DEPTH;
  endfunction

  // Mean window target scaled by weighted actual time over weighted ideal time.
  function automatic logic [TGT_W-1:0] window_target();
    logic [127:0]    weighted, tsum, prod, divisor, quot;
    logic [TS_W-1:0] t_new, t_old;
    int              back;
    weighted = '0;
    tsum     = '0;
    for (int k = 1; k <= WIN; k++) begin
      back  = WIN + 1 - k;
      t_new = ts_hist[slot_back(back)];
      t_old = ts_hist[slot_back(back + 1)];
      if (t_new > t_old) weighted += 128'(t_new - t_old) * 128'(k);
      tsum += 128'(tgt_hist[slot_back(back)]);
    end
    prod    = tsum * weighted;
    divisor = 128'(WIN) * 128'(cfg_ideal) * 128'(WIN * (WIN + 1) / 2);
    if (divisor == 0) return '1;
    quot = prod / divisor;
    return (quot[127:64] != 0) ? '1 : quot[63:0];
  endfunction

  function automatic retarget_result_t predict_next_target(input logic [TS_W-1:0] ts);
    retarget_result_t res;
    head           = (head + 1) % DEPTH;
    ts_hist[head]  = ts;
    tgt_hist[head] = cur_target;
    if (blocks_seen <= WIN) blocks_seen++;
    cur_target = (blocks_seen > WIN) ? window_target() : cfg_init;
    res.next_target = cur_target;
    res.warming_up  = (blocks_seen <= WIN);
    return res;
  endfunction

  // Mostly intervals around the ideal time, now and then a repeat, a step back
  // or a jump to anywhere in the timestamp range.
  function automatic logic [TS_W-1:0] paced_timestamp();
    logic [TS_W:0]  sum;
    logic [TS_W:0]  step_len;
    logic [63:0]    r;
    int unsigned    pace;
    int unsigned    roll;
    pace = (cfg_ideal == 0) ? 32'(IDEAL_RST) : 32'(cfg_ideal);
    roll = $urandom_range(399);
    r    = {$urandom, $urandom};
    if (roll < 2) begin
      sum = {1'b0, r[TS_W-1:0]};
    end else if (roll < 12) begin
      sum = {1'b0, last_ts};
    end else if (roll < 16) begin
      step_len = (TS_W + 1)'($urandom_range(pace));
      sum = {1'b0, last_ts} - step_len;
    end else begin
      step_len = (TS_W + 1)'($urandom_range(2 * pace, pace / 2));
      sum = {1'b0, last_ts} + step_len;
    end
    if (sum[TS_W]) sum = (TS_W + 1)'(pace);
    return sum[TS_W-1:0];
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic send_block(input logic [TS_W-1:0] ts);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct)
      gap = $urandom_range(1) ? $urandom_range(300, 1) : $urandom_range(4, 1);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ts;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    last_ts = ts;
    pending_targets.push_back(predict_next_target(ts));
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_targets.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IDEAL: cfg_ideal = value[IDEAL_W-1:0];
      REG_INIT: begin
        cfg_init = value[TGT_W-1:0];
        if (blocks_seen == 0) tgt_hist[head] = value[TGT_W-1:0];
        if (blocks_seen <= WIN) cur_target = value[TGT_W-1:0];
      end
      REG_GENESIS: begin
        // Only lands in the history before the first block.
        if (blocks_seen == 0) ts_hist[head] = value[TS_W-1:0];
      end
      default: ;
    endcase
  endtask

  // Warm-up with target rewrites and a late genesis write, then the first retargets.
  task automatic test_warm_up();
    logic [63:0] r;
    sender_idle_pct   = 35;
    receiver_idle_pct = 79;
    write_reg(REG_GENESIS, 64'h0000_00ff_ffff_ffff);
    write_reg(REG_INIT, '1);
    write_reg(REG_IDEAL, 64'(IDEAL_RST));
    r = {$urandom, $urandom};
    last_ts = {1'b0, r[TS_W-2:0]};
    send_block(paced_timestamp());
    drain_results();
    write_reg(REG_INIT, 64'd1);
    write_reg(REG_GENESIS, '0);
    repeat (2) send_block(paced_timestamp());
    drain_results();
    r = {$urandom, $urandom};
    write_reg(REG_INIT, {2'b01, r[61:0]});
    repeat (WIN - 1) send_block(paced_timestamp());
  endtask

  task automatic test_timestamp_extremes();
    send_block(last_ts);
    send_block({TS_W{1'b1}});
    send_block('0);
    repeat (3) send_block(paced_timestamp());
  endtask

  // A zero ideal time saturates; the smallest and largest swing the target hard.
  task automatic test_ideal_extremes();
    drain_results();
    write_reg(REG_IDEAL, '0);
    repeat (3) send_block(paced_timestamp());
    drain_results();
    write_reg(REG_IDEAL, 64'h0000_0000_0000_ffff);
    repeat (4) send_block(paced_timestamp());
    drain_results();
    write_reg(REG_IDEAL, 64'd1);
    repeat (4) send_block(paced_timestamp());
    drain_results();
    write_reg(REG_IDEAL, 64'(IDEAL_RST));
  endtask

  task automatic test_random_traffic(input int count, input int unsigned s_pct,
                                     input int unsigned r_pct);
    sender_idle_pct   = s_pct;
    receiver_idle_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 120 == 0) begin
        drain_results();
        write_reg(REG_IDEAL, 64'($urandom_range(2000, 300)));
        if ($urandom_range(1)) write_reg(REG_INIT, {$urandom, $urandom});
        if ($urandom_range(1)) write_reg(REG_GENESIS, {$urandom, $urandom});
      end
      send_block(paced_timestamp());
    end
  endtask

  // The output is held off while blocks keep coming, so the input has to stall.
  task automatic test_back_pressure();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    fork
      begin
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output <= 1'b0;
      end
      repeat (12) send_block(paced_timestamp());
    join
  endtask

  always @(posedge clk_i)
    m_axis_tready_i <= !hold_output && ($urandom_range(99) >= receiver_idle_pct);

  always @(posedge clk_i) begin
    retarget_result_t want, got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.next_target = m_axis_tdata_o;
      got.warming_up  = m_axis_tuser_o;
      if (pending_targets.size() == 0) begin
        note_failure($sformatf("unexpected result target %h warming_up %b",
                               got.next_target, got.warming_up));
      end else begin
        want = pending_targets.pop_front();
        if (got.next_target !== want.next_target || got.warming_up !== want.warming_up)
          note_failure($sformatf("expected target %h warming_up %b, got %h warming_up %b",
                                 want.next_target, want.warming_up,
                                 got.next_target, got.warming_up));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("lwma_difficulty_retarget_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      ts_hist[i]  = '0;
      tgt_hist[i] = '0;
    end
    ts_hist[0]  = GENESIS_RST;
    tgt_hist[0] = INIT_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_warm_up();
    test_timestamp_extremes();
    test_ideal_extremes();
    test_random_traffic(480, 35, 79);
    test_random_traffic(480, 79, 35);
    test_random_traffic(480, 0, 0);
    test_back_pressure();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_targets.size() == 0) begin
      $display("lwma_difficulty_retarget_tb passed");
    end else begin
      $display("lwma_difficulty_retarget_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lwma_pkg.sv
hdl/lwma_walk.sv
hdl/lwma_mul.sv
hdl/lwma_div.sv
hdl/lwma_difficulty_retarget.sv
bench/lwma_difficulty_retarget_tb.sv
